FILE: rtl/core/pfa_pkg.sv
// shared constants, codes and types for the partition fit allocator
// no dependencies; used by pfa_fit_unit, partition_fit_allocator_top and tb_top
package pfa_pkg;

    // defaults for the top level parameters
    localparam int NUM_BLOCKS_DEF = 16;
    localparam int SIZE_BITS_DEF  = 16;

    // fit policy codes
    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    // configuration register map
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 5;
    localparam logic [CFG_INDEX_W-1:0] REG_FIT_POLICY  = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_COUNT = 1'd1;

    localparam logic [1:0]            FIT_POLICY_RESET  = FIT_FIRST;
    localparam logic [CFG_DATA_W-1:0] BLOCK_COUNT_RESET = 5'd16;

    // control from the sequencer to the fit unit
    typedef struct packed {
        logic clear;   // start of a new search
        logic valid;   // candidate entry present this cycle
    } fit_ctl_t;

endpackage

FILE: rtl/core/pfa_fit_unit.sv
// compare unit: checks one candidate partition per cycle and keeps the pick
// depends on pfa_pkg (policy codes, fit_ctl_t)
module pfa_fit_unit #(
    parameter int SIZE_BITS = pfa_pkg::SIZE_BITS_DEF,
    parameter int IDX_W     = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pfa_pkg::fit_ctl_t    ctl,
    input  logic [1:0]           policy,
    input  logic [SIZE_BITS-1:0] req,
    input  logic [SIZE_BITS-1:0] cand_size,
    input  logic [IDX_W-1:0]     cand_idx,
    output logic                 found,
    output logic [SIZE_BITS-1:0] best_size,
    output logic [IDX_W-1:0]     best_idx
);

    logic                 found_reg;
    logic [SIZE_BITS-1:0] best_size_reg;
    logic [IDX_W-1:0]     best_idx_reg;
    logic                 fits;
    logic                 better;
    logic                 take;

    assign fits = (cand_size >= req);

    always_comb
    begin
        unique case (policy)
            pfa_pkg::FIT_BEST:  better = !found_reg || (cand_size < best_size_reg);
            pfa_pkg::FIT_WORST: better = !found_reg || (cand_size > best_size_reg);
            default:            better = !found_reg;
        endcase
    end

    assign take = ctl.valid && fits && better;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (ctl.clear)
        begin
            found_reg <= 1'b0;
        end
        else if (take)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && !ctl.clear)
        begin
            best_size_reg <= cand_size;
            best_idx_reg  <= cand_idx;
        end
    end

    assign found     = found_reg;
    assign best_size = best_size_reg;
    assign best_idx  = best_idx_reg;

endmodule

FILE: rtl/core/partition_fit_allocator_top.sv
// top level of the partition fit allocator: tables, sequencer, stream and config ports
// depends on pfa_pkg and pfa_fit_unit
//
// a load beat, or a request beat with nothing in use, goes straight to write-back; any other
//   request beat reads each in-use partition from the free table through the single read
//   port, drains the last compare, then writes back once the output register is free; a beat
//   with tlast set then sweeps all NUM_BLOCKS entries to copy saved sizes back
// one beat at a time; the next beat is taken once the result sits in the output register and
//   any restore sweep is done; reset clears the sequencer and the output register, sets the
//   config registers to defaults; size tables are not cleared and hold garbage until loaded
module partition_fit_allocator_top #(
    parameter int NUM_BLOCKS = pfa_pkg::NUM_BLOCKS_DEF,
    parameter int SIZE_BITS  = pfa_pkg::SIZE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [pfa_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pfa_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [39:0]                     s_tdata,  // mode, part_index, part_size, request_size, pad
    input  logic                            s_tlast,  // batch_end
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [23:0]                     m_tdata,  // granted, block_index, free_after, pad
    output logic                            m_tlast   // batch_done
);

    // table index width and a counter width that can also hold the table depth
    localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);

    // sequencer states
    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_SCAN    = 2'd1;
    localparam logic [1:0] ST_WB      = 2'd2;
    localparam logic [1:0] ST_RESTORE = 2'd3;

    // unpacked input fields
    logic        in_mode;
    logic [3:0]  in_part_index;
    logic [15:0] in_part_size;
    logic [15:0] in_request_size;

    assign in_mode         = s_tdata[0];
    assign in_part_index   = s_tdata[4:1];
    assign in_part_size    = s_tdata[20:5];
    assign in_request_size = s_tdata[36:21];

    // configuration registers
    logic [1:0]                     fit_policy_reg;
    logic [pfa_pkg::CFG_DATA_W-1:0] block_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_policy_reg  <= pfa_pkg::FIT_POLICY_RESET;
            block_count_reg <= pfa_pkg::BLOCK_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pfa_pkg::REG_FIT_POLICY:  fit_policy_reg  <= cfg_wdata[1:0];
                pfa_pkg::REG_BLOCK_COUNT: block_count_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // sequencer and datapath registers
    logic [1:0]           state_reg,    state_next;
    logic [CNT_W-1:0]     rd_idx_reg,   rd_idx_next;    // next table entry to read
    logic [CNT_W-1:0]     limit_reg,    limit_next;     // entries to sweep
    logic                 pv_reg,       pv_next;        // read data valid this cycle
    logic [IDX_W-1:0]     cmp_idx_reg,  cmp_idx_next;   // entry behind the read data
    logic [SIZE_BITS-1:0] req_reg,      req_next;
    logic                 bend_reg,     bend_next;

    // output register
    logic                 m_valid_reg,  m_valid_next;
    logic                 out_granted_reg;
    logic [3:0]           out_idx_reg;
    logic [15:0]          out_free_reg;
    logic                 out_last_reg;

    // size tables
    logic [SIZE_BITS-1:0] free_mem [NUM_BLOCKS];
    logic [SIZE_BITS-1:0] orig_mem [NUM_BLOCKS];
    logic [SIZE_BITS-1:0] free_q;
    logic [SIZE_BITS-1:0] orig_q;

    logic                 accept;
    logic                 issue;
    logic                 out_free;
    logic                 wb_fire;
    logic                 load_hit;
    logic [CNT_W-1:0]     limit_calc;
    logic [IDX_W-1:0]     rd_addr;
    logic [IDX_W-1:0]     load_addr;
    logic [SIZE_BITS-1:0] load_size;
    logic [SIZE_BITS-1:0] remain;

    // free-table write port
    logic                 fw_en;
    logic [IDX_W-1:0]     fw_addr;
    logic [SIZE_BITS-1:0] fw_data;

    // fit unit wiring
    pfa_pkg::fit_ctl_t    fit_ctl;
    logic                 fit_found;
    logic [SIZE_BITS-1:0] fit_best;
    logic [IDX_W-1:0]     fit_best_idx;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign issue    = (rd_idx_reg < limit_reg);
    assign out_free = !m_valid_reg || m_tready;
    assign wb_fire  = (state_reg == ST_WB) && out_free;
    assign rd_addr  = rd_idx_reg[IDX_W-1:0];

    // loads past the table end are dropped
    assign load_hit  = accept && !in_mode && (32'(in_part_index) < 32'(NUM_BLOCKS));
    assign load_addr = IDX_W'(in_part_index);
    assign load_size = SIZE_BITS'(32'(in_part_size));

    // in-use count, saturated at the table depth
    assign limit_calc = (32'(block_count_reg) > 32'(NUM_BLOCKS))
                      ? CNT_W'(NUM_BLOCKS) : CNT_W'(block_count_reg);

    assign remain = fit_best - req_reg;

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        rd_idx_next  = rd_idx_reg;
        limit_next   = limit_reg;
        pv_next      = 1'b0;
        cmp_idx_next = cmp_idx_reg;
        req_next     = req_reg;
        bend_next    = bend_reg;
        fit_ctl      = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    fit_ctl.clear = 1'b1;
                    req_next      = SIZE_BITS'(32'(in_request_size));
                    bend_next     = s_tlast;
                    rd_idx_next   = '0;
                    limit_next    = limit_calc;
                    // a load, or a request with nothing in use, goes straight to write-back
                    if (in_mode && (limit_calc != '0))
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_WB;
                    end
                end
            end
            ST_SCAN:
            begin
                fit_ctl.valid = pv_reg;
                pv_next       = issue;
                cmp_idx_next  = rd_addr;
                if (issue)
                begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                else
                begin
                    // last compare lands at this edge
                    state_next = ST_WB;
                end
            end
            ST_WB:
            begin
                if (out_free)
                begin
                    if (bend_reg)
                    begin
                        state_next  = ST_RESTORE;
                        rd_idx_next = '0;
                        limit_next  = CNT_W'(NUM_BLOCKS);
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_RESTORE:
            begin
                pv_next      = issue;
                cmp_idx_next = rd_addr;
                if (issue)
                begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // free-table write select: load, grant write-back, or restore copy
    always_comb
    begin
        fw_en   = 1'b0;
        fw_addr = load_addr;
        fw_data = load_size;
        priority if (load_hit)
        begin
            fw_en = 1'b1;
        end
        else if (wb_fire && fit_found)
        begin
            fw_en   = 1'b1;
            fw_addr = fit_best_idx;
            fw_data = remain;
        end
        else if ((state_reg == ST_RESTORE) && pv_reg)
        begin
            fw_en   = 1'b1;
            fw_addr = cmp_idx_reg;
            fw_data = orig_q;
        end
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end
        if (wb_fire)
        begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            rd_idx_reg  <= '0;
            limit_reg   <= '0;
            pv_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rd_idx_reg  <= rd_idx_next;
            limit_reg   <= limit_next;
            pv_reg      <= pv_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= cmp_idx_next;
        req_reg     <= req_next;
        bend_reg    <= bend_next;
        if (wb_fire)
        begin
            out_granted_reg <= fit_found;
            out_idx_reg     <= fit_found ? 4'(fit_best_idx) : 4'd0;
            out_free_reg    <= fit_found ? 16'(32'(remain)) : 16'd0;
            out_last_reg    <= bend_reg;
        end
    end

    // free-size table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (fw_en)
        begin
            free_mem[fw_addr] <= fw_data;
        end
        if (issue && (state_reg == ST_SCAN))
        begin
            free_q <= free_mem[rd_addr];
        end
    end

    // saved original sizes: written by loads, read during restore
    always_ff @(posedge clk)
    begin
        if (load_hit)
        begin
            orig_mem[load_addr] <= load_size;
        end
        if (issue && (state_reg == ST_RESTORE))
        begin
            orig_q <= orig_mem[rd_addr];
        end
    end

    pfa_fit_unit #(
        .SIZE_BITS (SIZE_BITS),
        .IDX_W     (IDX_W)
    ) u_fit (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (fit_ctl),
        .policy    (fit_policy_reg),
        .req       (req_reg),
        .cand_size (free_q),
        .cand_idx  (cmp_idx_reg),
        .found     (fit_found),
        .best_size (fit_best),
        .best_idx  (fit_best_idx)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'd0, out_free_reg, out_idx_reg, out_granted_reg};
    assign m_tlast  = out_last_reg;

    // a refused request reports index and remaining size as zero
    a_no_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[0]) |-> (m_tdata[20:1] == 20'd0))
        else $error("refused request carries nonzero index or size");

    // the sweep counter never runs past its limit
    a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SCAN) || (state_reg == ST_RESTORE)) |-> (rd_idx_reg <= limit_reg))
        else $error("table sweep ran past its limit");

    // a picked partition always covers the request
    a_pick_fits: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_WB) && fit_found) |-> (fit_best >= req_reg))
        else $error("picked partition smaller than the request");

    // a batch end always runs the restore sweep after write-back
    a_restore_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (wb_fire && bend_reg) |=> (state_reg == ST_RESTORE))
        else $error("batch end did not start the restore sweep");

endmodule

FILE: tb/sv/tb_top.sv
// self-checking testbench for partition_fit_allocator_top: directed and random beats
// against an in-bench fit predictor; depends on pfa_pkg and the allocator rtl
`timescale 1ns / 1ps

module tb_top;

    localparam int         NBLK       = pfa_pkg::NUM_BLOCKS_DEF;
    localparam bit         MODE_LOAD  = 1'b0;
    localparam bit         MODE_ALLOC = 1'b1;
    localparam logic [1:0] FIT_SPARE  = 2'd3;  // unused policy code, acts as first fit
    localparam int         SETTLE_CYC = 2 * NBLK + 8;  // request scan plus restore pass

    typedef struct packed {
        bit        granted;
        bit [3:0]  block_index;
        bit [15:0] free_after;
        bit        batch_done;
    } alloc_result_t;

    logic                            clk;
    logic                            rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [pfa_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [pfa_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [39:0]                     s_tdata = '0;  // mode, part_index, part_size, request_size, pad
    logic                            s_tlast = 1'b0;  // batch_end
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [23:0]                     m_tdata;  // granted, block_index, free_after, pad
    logic                            m_tlast;  // batch_done

    partition_fit_allocator_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // predictor state: live free sizes, loaded sizes and the two registers
    bit [15:0] free_tbl [NBLK];
    bit [15:0] orig_tbl [NBLK];
    bit [1:0]  policy_cfg = pfa_pkg::FIT_POLICY_RESET;
    bit [4:0]  blocks_cfg = pfa_pkg::BLOCK_COUNT_RESET;

    alloc_result_t pending_results [$];

    int err_count   = 0;
    int load_beats  = 0;
    int alloc_beats = 0;
    int grant_count = 0;
    int batch_count = 0;
    int cfg_writes  = 0;
    int burst_left  = 1;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // generous limit, well above the slowest legal run
    initial
    begin
        #5_000_000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("partition_fit_allocator_top regression: fail");
        $finish;
    end

    // table load or fit search over the in-use partitions, then the optional restore
    function automatic alloc_result_t predict_alloc(bit mode, bit [3:0] idx,
                                                    bit [15:0] psize, bit [15:0] req,
                                                    bit bend);
        alloc_result_t r;
        int            limit;
        int            pick;
        bit            found;
        r     = '0;
        pick  = 0;
        found = 1'b0;
        if (mode == MODE_LOAD)
        begin
            free_tbl[idx] = psize;
            orig_tbl[idx] = psize;
        end
        else
        begin
            limit = (blocks_cfg > NBLK) ? NBLK : int'(blocks_cfg);
            for (int j = 0; j < limit; j++)
            begin
                if (free_tbl[j] >= req)
                begin
                    if (!found)
                    begin
                        found = 1'b1;
                        pick  = j;
                        // first fit and the spare code stop at the first hit
                        if (policy_cfg != pfa_pkg::FIT_BEST && policy_cfg != pfa_pkg::FIT_WORST)
                            break;
                    end
                    else if (policy_cfg == pfa_pkg::FIT_BEST && free_tbl[j] < free_tbl[pick])
                        pick = j;
                    else if (policy_cfg == pfa_pkg::FIT_WORST && free_tbl[j] > free_tbl[pick])
                        pick = j;
                end
            end
            if (found)
            begin
                free_tbl[pick] = free_tbl[pick] - req;
                r.granted      = 1'b1;
                r.block_index  = pick[3:0];
                r.free_after   = free_tbl[pick];
            end
        end
        if (bend)
            free_tbl = orig_tbl;
        r.batch_done = bend;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        err_count++;
    endtask

    // one beat on the input stream; keeps tvalid up inside a burst
    task automatic send_beat(bit mode, bit [3:0] idx, bit [15:0] psize,
                             bit [15:0] req, bit bend);
        int gap;
        pending_results.push_back(predict_alloc(mode, idx, psize, req, bend));
        if (mode == MODE_LOAD)
            load_beats++;
        else
            alloc_beats++;
        if (bend)
            batch_count++;
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, req, psize, idx, mode};
        s_tlast  <= bend;
        do
            @(posedge clk);
        while (!s_tready);
        burst_left--;
        if (burst_left <= 0)
        begin
            // end of burst: drop valid for a random gap, then pick a new burst length
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 6);
        end
    endtask

    // sender pause: wait for every result plus the restore pass
    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_reg(logic [pfa_pkg::CFG_INDEX_W-1:0] idx,
                             logic [pfa_pkg::CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == pfa_pkg::REG_FIT_POLICY)
            policy_cfg = val[1:0];
        else
            blocks_cfg = val;
        cfg_writes++;
        @(posedge clk);
    endtask

    // result checker and receiver stall pattern share the clock edge
    int rx_cycle = 0;
    int rx_hold  = 0;
    always @(posedge clk)
    begin
        alloc_result_t want;
        if (m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result beat", 1, 0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[0] !== want.granted)
                    report_mismatch("granted", m_tdata[0], want.granted);
                if (m_tdata[4:1] !== want.block_index)
                    report_mismatch("block_index", m_tdata[4:1], want.block_index);
                if (m_tdata[20:5] !== want.free_after)
                    report_mismatch("free_after", m_tdata[20:5], want.free_after);
                if (m_tlast !== want.batch_done)
                    report_mismatch("batch_done", m_tlast, want.batch_done);
                if (m_tdata[0] === 1'b1)
                    grant_count++;
            end
        end
        // stall mode rotates through: open, coin flip, sparse, long holds
        rx_cycle++;
        case ((rx_cycle >> 7) % 4)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= ($urandom_range(0, 4) == 0);
            default:
            begin
                if (rx_hold == 0)
                begin
                    rx_hold = $urandom_range(1, 15);
                    m_tready <= ~m_tready;
                end
                else
                    rx_hold--;
            end
        endcase
    end

    // every partition gets a size before any scan can touch it
    task automatic test_table_load;
        bit [15:0] sizes [NBLK];
        sizes = '{16'd100, 16'd500, 16'd0, 16'd65535, 16'd200, 16'd300, 16'd500, 16'd50,
                  16'd1000, 16'd2000, 16'd150, 16'd4096, 16'd65535, 16'd7, 16'd8,
                  16'd12345};
        for (int i = 0; i < NBLK; i++)
            send_beat(MODE_LOAD, i[3:0], sizes[i], 16'hFFFF, 1'b0);
    endtask

    // same requests under each policy code, including the spare one
    task automatic test_policies;
        logic [1:0] pols [4];
        pols = '{pfa_pkg::FIT_FIRST, pfa_pkg::FIT_BEST, pfa_pkg::FIT_WORST, FIT_SPARE};
        for (int p = 0; p < 4; p++)
        begin
            drain();
            write_reg(pfa_pkg::REG_FIT_POLICY, {3'b000, pols[p]});
            send_beat(MODE_ALLOC, 4'hF, 16'hFFFF, 16'd200, 1'b0);
            send_beat(MODE_ALLOC, 4'h0, 16'h0000, 16'd0, 1'b0);     // zero request
            send_beat(MODE_ALLOC, 4'h5, 16'h1234, 16'd500, 1'b1);   // batch end on request
        end
    endtask

    // zero, single, saturated block counts and the largest request
    task automatic test_block_count;
        drain();
        write_reg(pfa_pkg::REG_FIT_POLICY, {3'b000, pfa_pkg::FIT_FIRST});
        write_reg(pfa_pkg::REG_BLOCK_COUNT, 5'd0);
        send_beat(MODE_ALLOC, 4'h0, 16'h0000, 16'd0, 1'b0);         // nothing scanned
        drain();
        write_reg(pfa_pkg::REG_BLOCK_COUNT, 5'd1);
        send_beat(MODE_ALLOC, 4'h0, 16'h0000, 16'd100, 1'b0);
        send_beat(MODE_ALLOC, 4'h0, 16'h0000, 16'hFFFF, 1'b1);
        drain();
        write_reg(pfa_pkg::REG_BLOCK_COUNT, 5'd31);                 // saturates to 16
        send_beat(MODE_ALLOC, 4'h0, 16'h0000, 16'hFFFF, 1'b0);
        send_beat(MODE_ALLOC, 4'h0, 16'h0000, 16'hFFFF, 1'b0);
        send_beat(MODE_ALLOC, 4'h0, 16'h0000, 16'hFFFF, 1'b0);     // both maxima used up
        send_beat(MODE_LOAD, 4'h7, 16'd60, 16'h0000, 1'b1);         // batch end on a load
        send_beat(MODE_ALLOC, 4'h0, 16'h0000, 16'd60, 1'b1);
    endtask

    function automatic bit [15:0] pick_size;
        if ($urandom_range(0, 2) == 0)
            return 16'($urandom);
        return 16'($urandom_range(0, 300));
    endfunction

    // batches of mostly requests shaped around the live table, under random settings
    task automatic test_random;
        int        batch_len;
        int        entry;
        int        sel;
        bit [15:0] req;
        bit        bend;
        for (int phase = 0; phase < 9; phase++)
        begin
            drain();
            write_reg(pfa_pkg::REG_FIT_POLICY, {3'b000, 2'($urandom_range(0, 3))});
            sel = $urandom_range(0, 9);
            if (sel == 0)
                write_reg(pfa_pkg::REG_BLOCK_COUNT, 5'd0);
            else if (sel == 1)
                write_reg(pfa_pkg::REG_BLOCK_COUNT, 5'($urandom_range(17, 31)));
            else if (sel == 2)
                write_reg(pfa_pkg::REG_BLOCK_COUNT, 5'd16);
            else
                write_reg(pfa_pkg::REG_BLOCK_COUNT, 5'($urandom_range(1, 16)));
            for (int n = 0; n < 50; n += batch_len)
            begin
                batch_len = $urandom_range(1, 12);
                for (int k = 0; k < batch_len; k++)
                begin
                    bend = (k == batch_len - 1);
                    if ($urandom_range(0, 9) < 3)
                        send_beat(MODE_LOAD, 4'($urandom_range(0, 15)), pick_size(),
                                  16'($urandom), bend);
                    else
                    begin
                        // aim at a live entry so grants and exact fits are common
                        entry = $urandom_range(0, NBLK - 1);
                        sel   = $urandom_range(0, 9);
                        if (sel <= 5)
                            req = 16'($urandom_range(0, free_tbl[entry]));
                        else if (sel == 6)
                            req = free_tbl[entry];
                        else if (sel == 7)
                            req = 16'd0;
                        else
                            req = 16'($urandom);
                        send_beat(MODE_ALLOC, 4'($urandom_range(0, 15)), 16'($urandom),
                                  req, bend);
                    end
                end
            end
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_table_load();
        test_policies();
        test_block_count();
        test_table_load();
        test_random();
        drain();
        $display("covered %0d loads and %0d requests, %0d granted, %0d batch ends",
                 load_beats, alloc_beats, grant_count, batch_count);
        $display("%0d register writes over every policy code, empty, partial and saturated counts",
                 cfg_writes);
        if (err_count == 0)
            $display("partition_fit_allocator_top regression: pass");
        else
            $display("partition_fit_allocator_top regression: fail");
        $finish;
    end

endmodule
